### rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared types, constants and tables for the card responder
// Holds the microcode program, the answer-to-reset and reply tables, and the
// byte coding helpers for the inverse-convention line.
// ----------------------------------------------------------------------------
package scr_pkg;

   // register indexes on the csr port
   localparam logic CSR_ATR_SELECT = 1'b0;
   localparam logic CSR_CLASS_BYTE = 1'b1;

   localparam logic [7:0] CLASS_RESET = 8'h53;

   // instruction codes
   localparam logic [7:0] INS_READ_A = 8'h70;
   localparam logic [7:0] INS_KEY    = 8'h74;
   localparam logic [7:0] INS_READ_B = 8'h78;
   localparam logic [7:0] INS_READ_C = 8'h7A;
   localparam logic [7:0] INS_READ_D = 8'h7C;

   // fixed reply bytes
   localparam logic [7:0] ACK_HI = 8'h90;
   localparam logic [7:0] ACK_LO = 8'h00;

   localparam logic [4:0] ATR_LAST_IDX = 5'd15;

   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // microcode operation
   typedef enum logic [2:0] {
      OP_FETCH    = 3'd0,
      OP_DISPATCH = 3'd1,
      OP_CLASS    = 3'd2,
      OP_HEADER   = 3'd3,
      OP_KEYTEST  = 3'd4,
      OP_SETLEN   = 3'd5,
      OP_PAYLOAD  = 3'd6,
      OP_EMIT     = 3'd7
   } op_type;

   // byte source for an emit step
   typedef enum logic [2:0] {
      SRC_ATR    = 3'd0,
      SRC_REPLY  = 3'd1,
      SRC_ACK_HI = 3'd2,
      SRC_ACK_LO = 3'd3,
      SRC_KEY    = 3'd4
   } src_type;

   typedef enum logic [1:0] {
      LAST_NO  = 2'd0,
      LAST_YES = 2'd1,
      LAST_END = 2'd2
   } last_type;

   typedef logic [3:0] step_type;

   // program step addresses
   localparam step_type ST_FETCH    = 4'd0;
   localparam step_type ST_DISPATCH = 4'd1;
   localparam step_type ST_ATR      = 4'd2;
   localparam step_type ST_CLASS    = 4'd3;
   localparam step_type ST_HEADER   = 4'd4;
   localparam step_type ST_KEYTEST  = 4'd5;
   localparam step_type ST_SETLEN   = 4'd6;
   localparam step_type ST_REPLY    = 4'd7;
   localparam step_type ST_ACK_HI   = 4'd8;
   localparam step_type ST_ACK_LO   = 4'd9;
   localparam step_type ST_KEY      = 4'd10;
   localparam step_type ST_PAYLOAD  = 4'd11;

   // one control word: op, emit source, last flag mode, loop on index,
   // clear protocol on completion, taken target and alternate target
   typedef struct packed {
      op_type   op;
      src_type  src;
      last_type lst;
      logic     loop;
      logic     clr;
      step_type next;
      step_type alt;
   } uword_type;

   function automatic uword_type scr_ucode(input step_type pc);
      uword_type w;
      w = '{op: OP_FETCH, src: SRC_ACK_HI, lst: LAST_NO, loop: 1'b0, clr: 1'b0,
            next: ST_DISPATCH, alt: ST_FETCH};
      unique case (pc)
         ST_FETCH:    w = '{OP_FETCH, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_DISPATCH, ST_FETCH};
         ST_DISPATCH: w = '{OP_DISPATCH, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_ATR, ST_FETCH};
         ST_ATR:      w = '{OP_EMIT, SRC_ATR, LAST_END, 1'b1, 1'b1, ST_FETCH, ST_FETCH};
         ST_CLASS:    w = '{OP_CLASS, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_FETCH, ST_FETCH};
         ST_HEADER:   w = '{OP_HEADER, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_KEYTEST, ST_FETCH};
         ST_KEYTEST:  w = '{OP_KEYTEST, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_SETLEN, ST_KEY};
         ST_SETLEN:   w = '{OP_SETLEN, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_REPLY, ST_ACK_HI};
         ST_REPLY:    w = '{OP_EMIT, SRC_REPLY, LAST_NO, 1'b1, 1'b0, ST_ACK_HI, ST_ACK_HI};
         ST_ACK_HI:   w = '{OP_EMIT, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_ACK_LO, ST_ACK_LO};
         ST_ACK_LO:   w = '{OP_EMIT, SRC_ACK_LO, LAST_YES, 1'b0, 1'b1, ST_FETCH, ST_FETCH};
         ST_KEY:      w = '{OP_EMIT, SRC_KEY, LAST_YES, 1'b0, 1'b0, ST_FETCH, ST_FETCH};
         ST_PAYLOAD:  w = '{OP_PAYLOAD, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_ACK_HI, ST_FETCH};
         default:     w = '{OP_FETCH, SRC_ACK_HI, LAST_NO, 1'b0, 1'b0, ST_DISPATCH, ST_FETCH};
      endcase
      return w;
   endfunction

   // reverse bit order and invert (inverse convention)
   function automatic logic [7:0] scr_flip(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return ~r;
   endfunction

   // line word: coded byte plus odd parity in bit 8
   function automatic logic [8:0] scr_encode(input logic [7:0] b);
      logic [7:0] c;
      c = scr_flip(b);
      return {~(^c), c};
   endfunction

   function automatic logic [7:0] scr_atr_byte(input logic sel, input logic [3:0] idx);
      logic [7:0] v;
      unique case (idx)
         4'd0:    v = 8'h3f;
         4'd1:    v = 8'hfa;
         4'd2:    v = sel ? 8'h12 : 8'h11;
         4'd3:    v = 8'h25;
         4'd4:    v = 8'h05;
         4'd5:    v = 8'h00;
         4'd6:    v = 8'h01;
         4'd7:    v = 8'hb0;
         4'd8:    v = 8'h02;
         4'd9:    v = 8'h3b;
         4'd10:   v = 8'h36;
         4'd11:   v = 8'h4d;
         4'd12:   v = 8'h59;
         4'd13:   v = 8'h02;
         4'd14:   v = 8'h80;
         default: v = 8'h81;
      endcase
      return v;
   endfunction

   // reply table length, zero for instructions without a table
   function automatic logic [4:0] scr_reply_len(input logic [7:0] ins);
      logic [4:0] n;
      unique case (ins)
         INS_READ_A: n = 5'd7;
         INS_READ_B: n = 5'd9;
         INS_READ_C: n = 5'd26;
         INS_READ_D: n = 5'd17;
         default:    n = 5'd0;
      endcase
      return n;
   endfunction

   // reply bytes: code echo first, then the canned body
   function automatic logic [7:0] scr_reply_byte(input logic [7:0] ins, input logic [4:0] idx);
      logic [7:0] v;
      v = 8'h00;
      unique case (ins)
         INS_READ_A: begin
            unique case (idx)
               5'd0:    v = INS_READ_A;
               5'd1:    v = 8'h2b;
               5'd2:    v = 8'h02;
               5'd3:    v = 8'h56;
               5'd4:    v = 8'h02;
               5'd5:    v = 8'h03;
               default: v = 8'h04;
            endcase
         end
         INS_READ_B: v = (idx == 5'd0) ? INS_READ_B : 8'hFF;
         INS_READ_C: begin
            priority if (idx == 5'd0) begin
               v = INS_READ_C;
            end else if (idx == 5'd1) begin
               v = 8'h80;
            end else begin
               v = 8'h20;
            end
         end
         INS_READ_D: v = (idx == 5'd0) ? INS_READ_D : 8'h00;
         default:    v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

### rtl/scr_req_if.sv
// ----------------------------------------------------------------------------
// scr_req_if: request channel
// Carries one received line byte or a card reset per item.
// ----------------------------------------------------------------------------
interface scr_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink   (input valid, command, rx_byte, output ready);
endinterface

### rtl/scr_rsp_if.sv
// ----------------------------------------------------------------------------
// scr_rsp_if: response channel
// Carries one nine-bit line word per item, with the end-of-run flag.
// ----------------------------------------------------------------------------
interface scr_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] tx_word;
   logic       last;

   modport source (output valid, tx_word, last, input ready);
   modport sink   (input valid, tx_word, last, output ready);
endinterface

### rtl/smart_card_command_responder.sv
// ----------------------------------------------------------------------------
// smart_card_command_responder: card side of an inverse-convention link
// Decodes line bytes, tracks the command header and sends answer-to-reset,
// canned replies and acknowledges, driven by a small microcode program.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | command, rx_byte
//  rsp     | out | valid / ready | tx_word, last
//  csr     | in  | csr_wr_en     | csr_index, csr_wr_data
//
// One program step per cycle while no step is held: an item is fetched and
// dispatched, then takes up to 3 bookkeeping steps and one emit step per word
// sent (reset item: 16 words, longest reply: 26 + 2 = 28). The single output
// register sets the pace: a stalled rsp holds the emit step, and req is taken
// only in the fetch step. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module smart_card_command_responder import scr_pkg::*; #(
   parameter int PAYLOAD_BYTES = 32
) (
   input  logic         clock,
   input  logic         reset,
   scr_req_if.sink      req,
   scr_rsp_if.source    rsp,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [7:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

   // sequencer and protocol state
   step_type   pc_ff, pc_in;
   phase_type  phase_ff, phase_in;
   logic [1:0] hc_ff, hc_in;
   logic [CNT_W-1:0] pcnt_ff, pcnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // configuration
   logic       atr_sel_ff, atr_sel_in;
   logic [7:0] class_ff, class_in;

   // datapath registers
   logic       cmd_ff, cmd_in;
   logic [7:0] rxb_ff, rxb_in;
   logic [7:0] ins_ff, ins_in;
   logic [7:0] len_ff, len_in;
   logic [4:0] idx_ff, idx_in;
   logic [4:0] end_ff, end_in;
   logic [8:0] word_ff, word_in;
   logic       last_ff, last_in;

   uword_type  uw;
   logic       out_free;
   logic [7:0] emit_byte;
   logic [4:0] tlen, tlen_m1;
   logic [CNT_W-1:0] pcnt_inc;

   assign uw       = scr_ucode(pc_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign tlen     = scr_reply_len(ins_ff);
   assign tlen_m1  = tlen - 5'd1;
   assign pcnt_inc = pcnt_ff + CNT_W'(1);

   // emit byte source
   always_comb begin
      unique case (uw.src)
         SRC_ATR:    emit_byte = scr_atr_byte(atr_sel_ff, idx_ff[3:0]);
         SRC_REPLY:  emit_byte = scr_reply_byte(ins_ff, idx_ff);
         SRC_ACK_HI: emit_byte = ACK_HI;
         SRC_ACK_LO: emit_byte = ACK_LO;
         SRC_KEY:    emit_byte = INS_KEY;
         default:    emit_byte = ACK_LO;
      endcase
   end

   // next values: execute the current control word
   always_comb begin
      pc_in        = pc_ff;
      phase_in     = phase_ff;
      hc_in        = hc_ff;
      pcnt_in      = pcnt_ff;
      cmd_in       = cmd_ff;
      rxb_in       = rxb_ff;
      ins_in       = ins_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      atr_sel_in   = atr_sel_ff;
      class_in     = class_ff;

      // configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ATR_SELECT: atr_sel_in = csr_wr_data[0];
            CSR_CLASS_BYTE: class_in   = csr_wr_data;
            default:        class_in   = class_ff;
         endcase
      end

      unique case (uw.op)
         OP_FETCH: begin
            if (req.valid) begin
               cmd_in = req.command;
               rxb_in = scr_flip(req.rx_byte);
               pc_in  = uw.next;
            end
         end
         OP_DISPATCH: begin
            if (cmd_ff) begin
               idx_in = 5'd0;
               end_in = ATR_LAST_IDX;
               pc_in  = uw.next;
            end else begin
               unique case (phase_ff)
                  PH_HEADER:  pc_in = ST_HEADER;
                  PH_PAYLOAD: pc_in = ST_PAYLOAD;
                  default:    pc_in = ST_CLASS;
               endcase
            end
         end
         OP_CLASS: begin
            phase_in = (rxb_ff == class_ff) ? PH_HEADER : PH_WAIT;
            hc_in    = 2'd0;
            pc_in    = uw.next;
         end
         OP_HEADER: begin
            if (hc_ff == 2'd0) begin
               ins_in = rxb_ff;
            end
            if (hc_ff == 2'd3) begin
               len_in = rxb_ff;
               hc_in  = 2'd0;
               pc_in  = uw.next;
            end else begin
               hc_in = hc_ff + 2'd1;
               pc_in = uw.alt;
            end
         end
         OP_KEYTEST: begin
            if (ins_ff == INS_KEY) begin
               phase_in = PH_PAYLOAD;
               pcnt_in  = '0;
               pc_in    = uw.alt;
            end else begin
               pc_in = uw.next;
            end
         end
         OP_SETLEN: begin
            // reply of min(P3 + 1, table length) bytes
            if (tlen == 5'd0) begin
               pc_in = uw.alt;
            end else begin
               idx_in = 5'd0;
               end_in = (len_ff > {3'b000, tlen_m1}) ? tlen_m1 : len_ff[4:0];
               pc_in  = uw.next;
            end
         end
         OP_PAYLOAD: begin
            pcnt_in = pcnt_inc;
            pc_in   = (pcnt_inc == CNT_W'(PAYLOAD_BYTES)) ? uw.next : uw.alt;
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               word_in      = scr_encode(emit_byte);
               unique case (uw.lst)
                  LAST_YES: last_in = 1'b1;
                  LAST_END: last_in = (idx_ff == end_ff);
                  default:  last_in = 1'b0;
               endcase
               if (uw.loop && (idx_ff != end_ff)) begin
                  idx_in = idx_ff + 5'd1;
               end else begin
                  pc_in = uw.next;
                  if (uw.clr) begin
                     phase_in = PH_WAIT;
                     hc_in    = 2'd0;
                  end
               end
            end
         end
         default: pc_in = ST_FETCH;
      endcase
   end

   // outputs
   always_comb begin
      req.ready   = (uw.op == OP_FETCH);
      rsp.valid   = rsp_valid_ff;
      rsp.tx_word = word_ff;
      rsp.last    = last_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_FETCH;
         phase_ff     <= PH_WAIT;
         hc_ff        <= 2'd0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         atr_sel_ff   <= 1'b1;
         class_ff     <= CLASS_RESET;
      end else begin
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         hc_ff        <= hc_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         atr_sel_ff   <= atr_sel_in;
         class_ff     <= class_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      rxb_ff  <= rxb_in;
      ins_ff  <= ins_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      end_ff  <= end_in;
      word_ff <= word_in;
      last_ff <= last_in;
   end

endmodule
